// File: hdl/smx_pkg.sv
// Shared types and constants for the stack machine executor.
// Opcodes, status codes, value selects and the controller/datapath structs.
// No dependencies.
package smx_pkg;

  localparam int DATA_W   = 32;
  localparam int OP_W     = 4;
  localparam int STATUS_W = 3;

  // Instruction opcodes; anything else is a bad opcode
  typedef enum logic [OP_W-1:0] {
    OP_PUSH  = 4'd0,
    OP_ADD   = 4'd1,
    OP_SUB   = 4'd2,
    OP_MUL   = 4'd3,
    OP_DIV   = 4'd4,
    OP_PRINT = 4'd5,
    OP_HALT  = 4'd6
  } op_t;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_PRINTED   = 3'd1,
    ST_HALTED    = 3'd2,
    ST_OVERFLOW  = 3'd3,
    ST_UNDERFLOW = 3'd4,
    ST_DIVZERO   = 3'd5,
    ST_BADOP     = 3'd6,
    ST_STOPPED   = 3'd7
  } status_t;

  // Source of the result value and of the word pushed to the stack
  typedef enum logic [2:0] {
    VS_ZERO  = 3'd0,
    VS_IMM   = 3'd1,
    VS_ALU   = 3'd2,
    VS_QUO   = 3'd3,
    VS_RDATA = 3'd4
  } vsel_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic    latch;      // capture the accepted instruction
    logic    pop;        // read top of stack, depth - 1
    logic    push;       // write selected value at depth, depth + 1
    logic    cap_b;      // capture read data as right operand
    logic    cap_a;      // capture read data as left operand
    logic    div_start;  // start divider on read data / right operand
    logic    res_load;   // load result status and value
    status_t res_status;
    vsel_t   vsel;
    logic    out_load;   // move result into the output register
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            stopped;
    logic            empty;
    logic            full;
    logic            rdata_zero;
    logic            div_done;
    logic            out_free;
  } stat_t;

endpackage

// File: hdl/smx_in_if.sv
// Instruction channel: valid/ready handshake with opcode and immediate.
// Depends on smx_pkg.
interface smx_in_if;
  logic                             valid;
  logic                             ready;
  logic [smx_pkg::OP_W-1:0]         func;
  logic signed [smx_pkg::DATA_W-1:0] immediate;

  modport source (output valid, func, immediate, input ready);
  modport sink   (input valid, func, immediate, output ready);
endinterface

// File: hdl/smx_out_if.sv
// Result channel: valid/ready handshake with status and value.
// Depends on smx_pkg.
interface smx_out_if;
  logic                              valid;
  logic                              ready;
  logic [smx_pkg::STATUS_W-1:0]      status;
  logic signed [smx_pkg::DATA_W-1:0] value;

  modport source (output valid, status, value, input ready);
  modport sink   (input valid, status, value, output ready);
endinterface

// File: hdl/smx_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies; contents are not reset.
module smx_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: hdl/smx_div.sv
// Bit-serial signed divider, one quotient bit per cycle, truncating toward zero.
// Depends on smx_pkg. Most negative / -1 wraps to most negative.
module smx_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [smx_pkg::DATA_W-1:0]   dividend,
  input  logic [smx_pkg::DATA_W-1:0]   divisor,
  output logic                         done,
  output logic [smx_pkg::DATA_W-1:0]   quotient
);

  localparam int DW = smx_pkg::DATA_W;
  localparam int NW = $clog2(DW + 1);

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [NW-1:0] cnt_r, cnt_nxt;
  logic [DW-1:0] rem_r, rem_nxt;
  logic [DW-1:0] quo_r, quo_nxt;
  logic [DW-1:0] dvs_r, dvs_nxt;
  logic          neg_r, neg_nxt;
  logic [DW:0]   trial;
  logic [DW:0]   diff;

  // Restoring step: shift in next dividend bit, try subtract
  assign trial = {rem_r, quo_r[DW-1]};
  assign diff  = trial - {1'b0, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    neg_nxt  = neg_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = NW'(DW);
      rem_nxt  = '0;
      quo_nxt  = dividend[DW-1] ? (~dividend + DW'(1)) : dividend;
      dvs_nxt  = divisor[DW-1] ? (~divisor + DW'(1)) : divisor;
      neg_nxt  = dividend[DW-1] ^ divisor[DW-1];
    end else if (busy_r) begin
      if (!diff[DW]) begin
        rem_nxt = diff[DW-1:0];
        quo_nxt = {quo_r[DW-2:0], 1'b1};
      end else begin
        rem_nxt = trial[DW-1:0];
        quo_nxt = {quo_r[DW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - NW'(1);
      if (cnt_r == NW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Operand and partial result registers
  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
    neg_r <= neg_nxt;
  end

  assign done     = done_r;
  assign quotient = neg_r ? (~quo_r + DW'(1)) : quo_r;

`ifndef SYNTHESIS
  // A new division never starts over one in progress
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r)
    else $error("divider started while busy");

  // Done comes exactly when the last iteration retires
  a_done_end: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r && $past(busy_r))
    else $error("divider done without a finished run");
`endif

endmodule

// File: hdl/smx_datapath.sv
// Stack memory, depth counter, operands, ALU, divider and result/output registers.
// Depends on smx_pkg, smx_ram and smx_div; driven by smx_ctrl commands.
module smx_datapath #(
  parameter int STACK_DEPTH = 256
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  smx_pkg::cmd_t                       cmd,
  output smx_pkg::stat_t                      stat,
  input  logic [smx_pkg::OP_W-1:0]            in_func,
  input  logic [smx_pkg::DATA_W-1:0]          in_immediate,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [smx_pkg::STATUS_W-1:0]        out_status,
  output logic [smx_pkg::DATA_W-1:0]          out_value
);

  localparam int DW = smx_pkg::DATA_W;
  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);

  logic [smx_pkg::OP_W-1:0] op_r;
  logic [DW-1:0]            imm_r;
  logic [DW-1:0]            a_r;
  logic [DW-1:0]            b_r;
  logic [CW-1:0]            depth_r, depth_nxt;
  logic                     stopped_r, stopped_nxt;
  smx_pkg::status_t         res_status_r;
  logic [DW-1:0]            res_value_r;
  logic                     out_valid_r, out_valid_nxt;
  smx_pkg::status_t         out_status_r;
  logic [DW-1:0]            out_value_r;

  logic [CW-1:0] depth_m1;
  logic [DW-1:0] rdata;
  logic [DW-1:0] alu;
  logic [DW-1:0] sel_value;
  logic          div_done;
  logic [DW-1:0] quo;

  assign depth_m1 = depth_r - CW'(1);

  // Stack storage
  smx_ram #(
    .WIDTH (DW),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (cmd.push),
    .waddr (depth_r[AW-1:0]),
    .wdata (sel_value),
    .re    (cmd.pop),
    .raddr (depth_m1[AW-1:0]),
    .rdata (rdata)
  );

  // Iterative divider: left operand comes straight from the stack read
  smx_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (rdata),
    .divisor  (b_r),
    .done     (div_done),
    .quotient (quo)
  );

  // Wrapping ALU for add, sub, mul
  always_comb begin
    case (op_r)
      smx_pkg::OP_ADD: alu = a_r + b_r;
      smx_pkg::OP_SUB: alu = a_r - b_r;
      smx_pkg::OP_MUL: alu = a_r * b_r;
      default:         alu = '0;
    endcase
  end

  // Value select for push data and result value
  always_comb begin
    case (cmd.vsel)
      smx_pkg::VS_IMM:   sel_value = imm_r;
      smx_pkg::VS_ALU:   sel_value = alu;
      smx_pkg::VS_QUO:   sel_value = quo;
      smx_pkg::VS_RDATA: sel_value = rdata;
      default:           sel_value = '0;
    endcase
  end

  // Depth, stop flag and output valid
  always_comb begin
    depth_nxt = depth_r;
    if (cmd.push) begin
      depth_nxt = depth_r + CW'(1);
    end else if (cmd.pop) begin
      depth_nxt = depth_m1;
    end
    stopped_nxt = stopped_r;
    if (cmd.res_load && cmd.res_status != smx_pkg::ST_OK &&
        cmd.res_status != smx_pkg::ST_PRINTED) begin
      stopped_nxt = 1'b1;
    end
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r     <= '0;
      stopped_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      depth_r     <= depth_nxt;
      stopped_r   <= stopped_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_r  <= in_func;
      imm_r <= in_immediate;
    end
    if (cmd.cap_a) begin
      a_r <= rdata;
    end
    if (cmd.cap_b) begin
      b_r <= rdata;
    end
    if (cmd.res_load) begin
      res_status_r <= cmd.res_status;
      res_value_r  <= sel_value;
    end
    if (cmd.out_load) begin
      out_status_r <= res_status_r;
      out_value_r  <= res_value_r;
    end
  end

  assign stat.op         = op_r;
  assign stat.stopped    = stopped_r;
  assign stat.empty      = (depth_r == '0);
  assign stat.full       = (depth_r == CW'(STACK_DEPTH));
  assign stat.rdata_zero = (rdata == '0);
  assign stat.div_done   = div_done;
  assign stat.out_free   = !out_valid_r || out_ready;

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_value  = out_value_r;

`ifndef SYNTHESIS
  // Once stopped, stays stopped until reset
  a_stop_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    stopped_r |=> stopped_r)
    else $error("stop flag cleared without reset");

  // No write beyond the top of a full stack
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.push |-> depth_r != CW'(STACK_DEPTH))
    else $error("push on full stack");

  // No read below the bottom of the stack
  a_pop_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pop |-> depth_r != '0)
    else $error("pop on empty stack");

  // Output register only reloaded when its transaction is done
  a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || out_ready))
    else $error("output overwritten before taken");
`endif

endmodule

// File: hdl/smx_ctrl.sv
// Controller state machine: sequences decode, stack pops, execute and result.
// Depends on smx_pkg; commands smx_datapath through cmd_t, reads stat_t.
module smx_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  smx_pkg::stat_t stat,
  output smx_pkg::cmd_t  cmd
);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_DECODE = 8'b0000_0010,
    S_PRINT  = 8'b0000_0100,
    S_POPB   = 8'b0000_1000,
    S_POPA   = 8'b0001_0000,
    S_EXEC   = 8'b0010_0000,
    S_DIV    = 8'b0100_0000,
    S_RESP   = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      // Wait for an instruction
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      // Dispatch on opcode, handle the cases that are resolved in decode
      S_DECODE: begin
        cmd.res_load = 1'b1;
        state_nxt    = S_RESP;
        if (stat.stopped) begin
          cmd.res_status = smx_pkg::ST_STOPPED;
        end else begin
          unique case (stat.op) inside
            smx_pkg::OP_PUSH: begin
              if (stat.full) begin
                cmd.res_status = smx_pkg::ST_OVERFLOW;
              end else begin
                cmd.push       = 1'b1;
                cmd.res_status = smx_pkg::ST_OK;
                cmd.vsel       = smx_pkg::VS_IMM;
              end
            end
            smx_pkg::OP_ADD, smx_pkg::OP_SUB, smx_pkg::OP_MUL, smx_pkg::OP_DIV: begin
              if (stat.empty) begin
                cmd.res_status = smx_pkg::ST_UNDERFLOW;
              end else begin
                cmd.res_load = 1'b0;
                cmd.pop      = 1'b1;
                state_nxt    = S_POPB;
              end
            end
            smx_pkg::OP_PRINT: begin
              if (stat.empty) begin
                cmd.res_status = smx_pkg::ST_UNDERFLOW;
              end else begin
                cmd.res_load = 1'b0;
                cmd.pop      = 1'b1;
                state_nxt    = S_PRINT;
              end
            end
            smx_pkg::OP_HALT: cmd.res_status = smx_pkg::ST_HALTED;
            default:          cmd.res_status = smx_pkg::ST_BADOP;
          endcase
        end
      end
      // Popped top is the printed value
      S_PRINT: begin
        cmd.res_load   = 1'b1;
        cmd.res_status = smx_pkg::ST_PRINTED;
        cmd.vsel       = smx_pkg::VS_RDATA;
        state_nxt      = S_RESP;
      end
      // Right operand arrives; zero divisor checked before second pop
      S_POPB: begin
        cmd.cap_b = 1'b1;
        if (stat.op == smx_pkg::OP_DIV && stat.rdata_zero) begin
          cmd.res_load   = 1'b1;
          cmd.res_status = smx_pkg::ST_DIVZERO;
          state_nxt      = S_RESP;
        end else if (stat.empty) begin
          cmd.res_load   = 1'b1;
          cmd.res_status = smx_pkg::ST_UNDERFLOW;
          state_nxt      = S_RESP;
        end else begin
          cmd.pop   = 1'b1;
          state_nxt = S_POPA;
        end
      end
      // Left operand arrives
      S_POPA: begin
        cmd.cap_a = 1'b1;
        if (stat.op == smx_pkg::OP_DIV) begin
          cmd.div_start = 1'b1;
          state_nxt     = S_DIV;
        end else begin
          state_nxt = S_EXEC;
        end
      end
      // Push ALU result
      S_EXEC: begin
        cmd.push       = 1'b1;
        cmd.res_load   = 1'b1;
        cmd.res_status = smx_pkg::ST_OK;
        cmd.vsel       = smx_pkg::VS_ALU;
        state_nxt      = S_RESP;
      end
      // Wait for quotient, then push it
      S_DIV: begin
        if (stat.div_done) begin
          cmd.push       = 1'b1;
          cmd.res_load   = 1'b1;
          cmd.res_status = smx_pkg::ST_OK;
          cmd.vsel       = smx_pkg::VS_QUO;
          state_nxt      = S_RESP;
        end
      end
      // Hand result to the output register once it is free
      S_RESP: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

`ifndef SYNTHESIS
  // Divider is started only from the second operand fetch
  a_div_from_popa: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |=> state_r == S_DIV)
    else $error("divider start outside operand fetch");

  // Every accepted instruction is decoded next
  a_accept_decode: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> state_r == S_DECODE)
    else $error("accepted instruction not decoded");
`endif

endmodule

// File: hdl/stack_machine_executor.sv
// Stack machine executor top level: one instruction in, one result out.
// Push, halt and decode errors are resolved in decode; print and errors after the first pop in the
// state that follows; add/sub/mul pass through both pops and execute; divide waits for the divider.
// One instruction at a time: the next is taken once the previous result is in the output register.
// Operand pops are serialized through the single read port; a held result stalls the block.
// Reset (rst_n, synchronous) clears depth, stop flag and output valid; stack not cleared.
module stack_machine_executor #(
  parameter int STACK_DEPTH = 256
) (
  input logic       clk,
  input logic       rst_n,
  smx_in_if.sink    in_ch,
  smx_out_if.source out_ch
);

  smx_pkg::cmd_t  cmd;
  smx_pkg::stat_t stat;
  logic           in_ready;
  logic           out_valid;
  logic [smx_pkg::STATUS_W-1:0] out_status;
  logic [smx_pkg::DATA_W-1:0]   out_value;

  // Sequencer
  smx_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Stack, arithmetic and result registers
  smx_datapath #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .stat         (stat),
    .in_func      (in_ch.func),
    .in_immediate (in_ch.immediate),
    .out_valid    (out_valid),
    .out_ready    (out_ch.ready),
    .out_status   (out_status),
    .out_value    (out_value)
  );

  assign in_ch.ready   = in_ready;
  assign out_ch.valid  = out_valid;
  assign out_ch.status = out_status;
  assign out_ch.value  = out_value;

endmodule

// File: tb/sv/stack_machine_executor_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for stack_machine_executor: directed and random instruction
// streams, a scoreboard class that predicts each result, random stalls on both channels.
// Depends on smx_pkg, smx_in_if, smx_out_if and the stack_machine_executor RTL.
module stack_machine_executor_tb;

  localparam int STACK_DEPTH  = 256;
  localparam int RANDOM_ITEMS = 1150;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int TAIL_CYCLES  = 60;
  localparam int DW           = smx_pkg::DATA_W;
  localparam int OW           = smx_pkg::OP_W;

  typedef struct packed {
    smx_pkg::status_t status;
    logic [DW-1:0]    value;
  } smx_result_t;

  // Ways the run can end; only one per run, since a stopped block needs a reset
  typedef enum int {
    END_HALT, END_BADOP, END_OVERFLOW, END_PRINT_EMPTY,
    END_ARITH_EMPTY, END_SECOND_POP, END_DIVZERO, END_DIVZERO_ALONE
  } ending_t;

  // Predicts one result per accepted instruction and checks results in order
  class stack_scoreboard;
    int unsigned   cap;
    logic [DW-1:0] stack_words [];
    int unsigned   depth;
    bit            stopped;
    smx_result_t   awaited [$];
    int            failures;
    int            results_seen;

    function new(int unsigned cap_words);
      cap          = cap_words;
      stack_words  = new[cap_words];
      depth        = 0;
      stopped      = 1'b0;
      failures     = 0;
      results_seen = 0;
    endfunction

    function logic [DW-1:0] top_value();
      return (depth == 0) ? '0 : stack_words[depth-1];
    endfunction

    function void flag(string what);
      failures++;
      if (failures <= 10) $display("error: %s", what);
    endfunction

    function logic [DW-1:0] arith(logic [OW-1:0] f, logic [DW-1:0] a, logic [DW-1:0] b);
      logic signed [2*DW-1:0] q;
      q = '0;
      case (f)
        smx_pkg::OP_ADD: return a + b;
        smx_pkg::OP_SUB: return a - b;
        smx_pkg::OP_MUL: return a * b;
        default: begin
          // 64-bit quotient truncates toward zero; min / -1 wraps back to min
          q = $signed({{DW{a[DW-1]}}, a}) / $signed({{DW{b[DW-1]}}, b});
          return q[DW-1:0];
        end
      endcase
    endfunction

    // Called once per accepted instruction transaction
    function void note_instr(logic [OW-1:0] f, logic [DW-1:0] imm);
      smx_result_t   r;
      logic [DW-1:0] a;
      logic [DW-1:0] b;
      r.status = smx_pkg::ST_OK;
      r.value  = '0;
      if (stopped) begin
        r.status = smx_pkg::ST_STOPPED;
      end else begin
        case (f)
          smx_pkg::OP_PUSH: begin
            if (depth < cap) begin
              stack_words[depth] = imm;
              depth++;
              r.value = imm;
            end else begin
              r.status = smx_pkg::ST_OVERFLOW;
            end
          end
          smx_pkg::OP_ADD, smx_pkg::OP_SUB, smx_pkg::OP_MUL, smx_pkg::OP_DIV: begin
            if (depth == 0) begin
              r.status = smx_pkg::ST_UNDERFLOW;
            end else begin
              // divisor is popped and tested before the left operand is popped
              depth--;
              b = stack_words[depth];
              if (f == smx_pkg::OP_DIV && b == '0) begin
                r.status = smx_pkg::ST_DIVZERO;
              end else if (depth == 0) begin
                r.status = smx_pkg::ST_UNDERFLOW;
              end else begin
                a = stack_words[depth-1];
                r.value = arith(f, a, b);
                stack_words[depth-1] = r.value;
              end
            end
          end
          smx_pkg::OP_PRINT: begin
            if (depth == 0) begin
              r.status = smx_pkg::ST_UNDERFLOW;
            end else begin
              depth--;
              r.status = smx_pkg::ST_PRINTED;
              r.value  = stack_words[depth];
            end
          end
          smx_pkg::OP_HALT: r.status = smx_pkg::ST_HALTED;
          default:          r.status = smx_pkg::ST_BADOP;
        endcase
        if (r.status != smx_pkg::ST_OK && r.status != smx_pkg::ST_PRINTED) begin
          stopped = 1'b1;
          r.value = '0;
        end
      end
      awaited.push_back(r);
    endfunction

    // Called once per accepted result transaction
    function void check_result(logic [smx_pkg::STATUS_W-1:0] got_status,
                               logic [DW-1:0] got_value);
      smx_result_t want;
      results_seen++;
      if (awaited.size() == 0) begin
        flag($sformatf("result %0d with nothing pending: status %0d value %h",
                       results_seen, got_status, got_value));
        return;
      end
      want = awaited.pop_front();
      if (got_status !== want.status)
        flag($sformatf("result %0d status: expected %0d got %0d",
                       results_seen, want.status, got_status));
      if (got_value !== want.value)
        flag($sformatf("result %0d value: expected %h got %h",
                       results_seen, want.value, got_value));
    endfunction

    function void close_out();
      while (awaited.size() != 0) begin
        void'(awaited.pop_front());
        flag("expected result never arrived");
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  bit   calm      = 1'b0;
  int   calm_left = 0;
  int   cycles    = 0;

  smx_in_if  in_ch ();
  smx_out_if out_ch ();

  stack_scoreboard sb = new(STACK_DEPTH);

  stack_machine_executor #(.STACK_DEPTH(STACK_DEPTH)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Alternate between stretches with no idling and stretches with random gaps
  always @(posedge clk) begin
    if (calm_left == 0) begin
      calm      <= ($urandom_range(0, 3) == 0);
      calm_left <= $urandom_range(100, 600);
    end else begin
      calm_left <= calm_left - 1;
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [DW-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return '0;
      3:       return '1;
      4:       return 32'd1;
      5, 6:    return int'($urandom_range(0, 32)) - 16;
      default: return $urandom;
    endcase
  endfunction

  function automatic smx_pkg::op_t pick_arith();
    case ($urandom_range(0, 3))
      0:       return smx_pkg::OP_ADD;
      1:       return smx_pkg::OP_SUB;
      2:       return smx_pkg::OP_MUL;
      default: return smx_pkg::OP_DIV;
    endcase
  endfunction

  // Result side: random backpressure
  initial begin
    int hold;
    hold = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold == 0 && $urandom_range(0, 3) == 0) hold = pick_gap();
      if (hold > 0) begin
        out_ch.ready <= 1'b0;
        hold--;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Result monitor
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_result(out_ch.status, out_ch.value);
  end

  // Drive one instruction; valid stays high on return so a back-to-back call can follow
  task automatic send_instr(input logic [OW-1:0] f, input logic [DW-1:0] imm);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.func      <= f;
    in_ch.immediate <= imm;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_instr(f, imm);
  endtask

  // Hold off until every pending result has come back
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (sb.awaited.size() != 0);
  endtask

  task automatic pop_down_to(input int unsigned level);
    while (sb.depth > level) send_instr(smx_pkg::OP_PRINT, pick_value());
  endtask

  initial begin
    int unsigned  target;
    int           phase_left;
    int           phases;
    bit           want_push;
    smx_pkg::op_t f;
    ending_t      ending;

    target     = 4;
    phase_left = 0;
    phases     = 0;
    rst_n           <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.func      <= '0;
    in_ch.immediate <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: wraparound, min / -1, truncation toward zero, print
    send_instr(smx_pkg::OP_PUSH, 32'h7FFF_FFFF);
    send_instr(smx_pkg::OP_PUSH, 32'd1);
    send_instr(smx_pkg::OP_ADD, '0);
    send_instr(smx_pkg::OP_PUSH, '1);
    send_instr(smx_pkg::OP_DIV, '1);
    send_instr(smx_pkg::OP_PRINT, 32'hFFFF_0000);
    send_instr(smx_pkg::OP_PUSH, 32'h8000_0000);
    send_instr(smx_pkg::OP_PUSH, 32'd1);
    send_instr(smx_pkg::OP_SUB, 32'h5555_5555);
    send_instr(smx_pkg::OP_PRINT, 32'hAAAA_AAAA);
    send_instr(smx_pkg::OP_PUSH, -32'sd7);
    send_instr(smx_pkg::OP_PUSH, 32'd2);
    send_instr(smx_pkg::OP_DIV, '0);
    send_instr(smx_pkg::OP_PRINT, '0);
    send_instr(smx_pkg::OP_PUSH, 32'h7FFF_FFFF);
    send_instr(smx_pkg::OP_PUSH, -32'sd7);
    send_instr(smx_pkg::OP_DIV, '0);
    send_instr(smx_pkg::OP_PUSH, 32'h1234_5678);
    send_instr(smx_pkg::OP_PUSH, 32'h9ABC_DEF0);
    send_instr(smx_pkg::OP_MUL, '0);
    send_instr(smx_pkg::OP_PRINT, '0);
    send_instr(smx_pkg::OP_PUSH, '0);
    wait_drained();

    // Random well-formed programs; depth wanders around a target, sometimes up to full
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (phase_left == 0) begin
        phases++;
        if (phases == 3 || $urandom_range(0, 7) == 0) begin
          target     = STACK_DEPTH;
          phase_left = 400;
        end else begin
          target     = $urandom_range(2, 12);
          phase_left = $urandom_range(30, 90);
        end
      end
      phase_left--;
      if (n % 400 == 399) wait_drained();

      if (sb.depth < 2) want_push = (sb.depth == 0) || ($urandom_range(0, 4) != 0);
      else if (sb.depth >= STACK_DEPTH) want_push = 1'b0;
      else if (sb.depth < target) want_push = ($urandom_range(0, 9) < 9);
      else want_push = ($urandom_range(0, 9) < 2);

      if (want_push) begin
        send_instr(smx_pkg::OP_PUSH, pick_value());
      end else if (sb.depth == 1 || $urandom_range(0, 4) == 0) begin
        send_instr(smx_pkg::OP_PRINT, pick_value());
      end else begin
        f = pick_arith();
        if (f == smx_pkg::OP_DIV && sb.top_value() == '0) f = smx_pkg::OP_SUB;
        send_instr(f, pick_value());
      end
    end

    // One stopping event, chosen at random
    ending = ending_t'($urandom_range(0, 7));
    case (ending)
      END_HALT:  send_instr(smx_pkg::OP_HALT, pick_value());
      END_BADOP: send_instr(4'($urandom_range(int'(smx_pkg::OP_HALT) + 1, 15)), pick_value());
      END_OVERFLOW: begin
        while (sb.depth < STACK_DEPTH) send_instr(smx_pkg::OP_PUSH, pick_value());
        send_instr(smx_pkg::OP_PUSH, pick_value());
      end
      END_PRINT_EMPTY: begin
        pop_down_to(0);
        send_instr(smx_pkg::OP_PRINT, pick_value());
      end
      END_ARITH_EMPTY: begin
        pop_down_to(0);
        send_instr(pick_arith(), pick_value());
      end
      END_SECOND_POP: begin
        pop_down_to(1);
        if (sb.depth == 0) send_instr(smx_pkg::OP_PUSH, 32'd3);
        f = pick_arith();
        if (f == smx_pkg::OP_DIV && sb.top_value() == '0) f = smx_pkg::OP_ADD;
        send_instr(f, pick_value());
      end
      END_DIVZERO: begin
        if (sb.depth >= STACK_DEPTH) pop_down_to(STACK_DEPTH - 1);
        send_instr(smx_pkg::OP_PUSH, '0);
        send_instr(smx_pkg::OP_DIV, pick_value());
      end
      default: begin
        // zero divisor alone on the stack: divide by zero wins over underflow
        pop_down_to(0);
        send_instr(smx_pkg::OP_PUSH, '0);
        send_instr(smx_pkg::OP_DIV, pick_value());
      end
    endcase

    // Stopped block: every opcode just reports stopped
    send_instr(4'hF, '1);
    repeat (15) send_instr(4'($urandom_range(0, 15)), pick_value());
    in_ch.valid <= 1'b0;

    while (sb.awaited.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    sb.close_out();
    if (sb.failures == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule

// File: stack_machine_executor.f
hdl/smx_pkg.sv
hdl/smx_in_if.sv
hdl/smx_out_if.sv
hdl/smx_ram.sv
hdl/smx_div.sv
hdl/smx_datapath.sv
hdl/smx_ctrl.sv
hdl/stack_machine_executor.sv
tb/sv/stack_machine_executor_tb.sv
